/* src/irpe_pkg.sv */
// ----------------------------------------------------------------------------
// irpe_pkg
// Shared types and constants of the infrared pulse-train encoder.
// ----------------------------------------------------------------------------
package irpe_pkg;

  localparam int LIST_W    = 64;
  localparam int SLOT_W    = 16;
  localparam int TICK_W    = 15;
  localparam int BIDX_W    = 7;
  localparam int GAP_W     = 18;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int NCMD      = 7;

  localparam logic [TICK_W-1:0] TICK_MAX = 15'h7FFF;
  localparam logic [BIDX_W-1:0] BIT_COUNT_RST = 7'd32;
  localparam logic [BIDX_W-1:0] RC6_DOUBLE_POS = 7'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BITCNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RC6     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd6;

  // command kinds between front and back
  localparam logic [2:0] CMD_HEADER  = 3'd0;
  localparam logic [2:0] CMD_TRAILER = 3'd1;
  localparam logic [2:0] CMD_ZERO    = 3'd2;
  localparam logic [2:0] CMD_ONE     = 3'd3;
  localparam logic [2:0] CMD_GAP     = 3'd4;

  // command slots of one item, in emission order
  localparam int SLOT_HDR = 0;
  localparam int SLOT_B0  = 1;
  localparam int SLOT_TRL = 5;
  localparam int SLOT_GAP = 6;

  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    logic             first;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic              pulse_level;
    logic [TICK_W-1:0] pulse_ticks;
    logic              run_end;
  } out_word_t;

  typedef struct packed {
    logic [LIST_W-1:0] header_pulses;
    logic [LIST_W-1:0] trailer_pulses;
    logic [LIST_W-1:0] zero_pulses;
    logic [LIST_W-1:0] one_pulses;
    logic [BIDX_W-1:0] bit_count;
    logic              rc6_mode;
    logic [GAP_W-1:0]  gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       dbl;
    logic       is_last;
  } cmd_t;

  typedef struct packed {
    logic              idle;
    logic [BIDX_W-1:0] bit_index;
  } front_status_t;

endpackage

/* src/irpe_stream_if.sv */
// ----------------------------------------------------------------------------
// irpe_stream_if
// Valid/ready stream channel carrying one payload item.
// ----------------------------------------------------------------------------
interface irpe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/ir_pulse_train_encoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_train_encoder
// Infrared remote pulse-train encoder: nibble items in, level/duration words out.
// ----------------------------------------------------------------------------
// throughput: one pulse word per cycle from the back end while the output is
//   ready, up to 33 for an item; the next item is taken once all commands of
//   the one before are in the queue, later when the queue is full; one command
//   per nonempty header, data bit or trailer list and per nonzero gap
// the front issues one command per cycle into a 4-entry queue while not full,
//   the back end expands each command into its words through one output register
// reset: config registers go to their defaults (bit count 32), queue empty
// ----------------------------------------------------------------------------
module ir_pulse_train_encoder
  import irpe_pkg::*;
#(
  parameter int SLOTS_PER_LIST = 4,
  parameter int MAX_BITS       = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LIST_W-1:0]    cfg_data,
  irpe_stream_if.sink          items,
  irpe_stream_if.source        pulses
);

  cfg_t          cfg;
  front_status_t fstat;
  logic          push;
  cmd_t          push_cmd;
  logic          full;
  logic          pop;
  cmd_t          head;
  logic          empty;
  in_item_t      in_data;
  out_word_t     out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_pulses  <= '0;
      cfg.trailer_pulses <= '0;
      cfg.zero_pulses    <= '0;
      cfg.one_pulses     <= '0;
      cfg.bit_count      <= BIT_COUNT_RST;
      cfg.rc6_mode       <= 1'b0;
      cfg.gap_ticks      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HEADER:  cfg.header_pulses  <= cfg_data;
        REG_TRAILER: cfg.trailer_pulses <= cfg_data;
        REG_ZERO:    cfg.zero_pulses    <= cfg_data;
        REG_ONE:     cfg.one_pulses     <= cfg_data;
        REG_BITCNT:  cfg.bit_count      <= cfg_data[BIDX_W-1:0];
        REG_RC6:     cfg.rc6_mode       <= cfg_data[0];
        REG_GAP:     cfg.gap_ticks      <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_data.nibble = items.data.nibble;
  assign in_data.first  = items.data.first;
  assign in_data.last   = items.data.last;

  irpe_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .status   (fstat)
  );

  irpe_cmd_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  irpe_back #(
    .SLOTS_PER_LIST (SLOTS_PER_LIST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (pulses.valid),
    .out_ready (pulses.ready),
    .out_data  (out_data)
  );

  assign pulses.data.pulse_level = out_data.pulse_level;
  assign pulses.data.pulse_ticks = out_data.pulse_ticks;
  assign pulses.data.run_end     = out_data.run_end;

  // a word never carries zero ticks
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    pulses.valid |-> (pulses.data.pulse_ticks != '0))
    else $error("pulse word with zero ticks");

  // frame end clears the bit position
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.data.last) |=> (fstat.bit_index == '0))
    else $error("bit position not cleared after last item");

  // bit position never runs past the bit limit
  a_bidx_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.bit_index <= BIDX_W'(MAX_BITS))
    else $error("bit position beyond limit");

  // input is only taken while the front has no commands left
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> fstat.idle)
    else $error("front ready with commands pending");

endmodule

/* src/irpe_front.sv */
// ----------------------------------------------------------------------------
// irpe_front
// Takes items, tracks bit position, issues one command per cycle unless full.
// ----------------------------------------------------------------------------
module irpe_front
  import irpe_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  input  cfg_t          cfg,
  output logic          push,
  output cmd_t          push_cmd,
  input  logic          full,
  output front_status_t status
);

  logic [NCMD-1:0]   pend;
  logic [NCMD-1:0]   pend_next;
  logic [NCMD-1:0]   bval;
  logic [NCMD-1:0]   bdbl;
  logic [BIDX_W-1:0] bit_index;

  logic [BIDX_W-1:0] base;
  logic [BIDX_W-1:0] limit;
  logic [BIDX_W:0]   pos [NIB_W];
  logic [NIB_W-1:0]  en;
  logic [2:0]        emit_cnt;
  logic [NCMD-1:0]   new_pend;
  logic [NCMD-1:0]   new_val;
  logic [NCMD-1:0]   new_dbl;
  logic              hdr_ne, trl_ne, zero_ne, one_ne;
  logic              accept;
  logic [NCMD-1:0]   pick;
  logic              found;

  assign in_ready = (pend == '0);
  assign accept   = in_valid && in_ready;

  assign hdr_ne  = (cfg.header_pulses[TICK_W-1:0] != '0);
  assign trl_ne  = (cfg.trailer_pulses[TICK_W-1:0] != '0);
  assign zero_ne = (cfg.zero_pulses[TICK_W-1:0] != '0);
  assign one_ne  = (cfg.one_pulses[TICK_W-1:0] != '0);

  assign base  = in_data.first ? '0 : bit_index;
  assign limit = (cfg.bit_count > BIDX_W'(MAX_BITS)) ? BIDX_W'(MAX_BITS) : cfg.bit_count;

  always_comb begin
    new_pend = '0;
    new_val  = '0;
    new_dbl  = '0;
    emit_cnt = '0;
    new_pend[SLOT_HDR] = in_data.first && hdr_ne;
    for (int k = 0; k < NIB_W; k++) begin
      pos[k] = {1'b0, base} + (BIDX_W+1)'(k);
      en[k]  = (pos[k] < {1'b0, limit});
      new_val[SLOT_B0+k] = in_data.nibble[NIB_W-1-k];
      new_dbl[SLOT_B0+k] = cfg.rc6_mode && (pos[k] == {1'b0, RC6_DOUBLE_POS});
      new_pend[SLOT_B0+k] = en[k] && (in_data.nibble[NIB_W-1-k] ? one_ne : zero_ne);
      emit_cnt = emit_cnt + 3'(en[k]);
    end
    new_pend[SLOT_TRL] = in_data.last && trl_ne;
    new_pend[SLOT_GAP] = in_data.last && (cfg.gap_ticks != '0);
  end

  // lowest pending slot goes out first
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int j = 0; j < NCMD; j++) begin
      if (pend[j] && !found) begin
        pick[j] = 1'b1;
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    push_cmd.is_last = ((pend & ~pick) == '0);
    push_cmd.dbl     = |(pick & bdbl);
    if (pick[SLOT_HDR]) begin
      push_cmd.kind = CMD_HEADER;
    end else if (pick[SLOT_TRL]) begin
      push_cmd.kind = CMD_TRAILER;
    end else if (pick[SLOT_GAP]) begin
      push_cmd.kind = CMD_GAP;
    end else if (|(pick & bval)) begin
      push_cmd.kind = CMD_ONE;
    end else begin
      push_cmd.kind = CMD_ZERO;
    end
  end

  assign push = found && !full;

  always_comb begin
    pend_next = pend;
    if (accept) begin
      pend_next = new_pend;
    end else if (push) begin
      pend_next = pend & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      bit_index <= '0;
    end else begin
      pend <= pend_next;
      if (accept) begin
        bit_index <= in_data.last ? '0 : base + BIDX_W'(emit_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bval <= new_val;
      bdbl <= new_dbl;
    end
  end

  assign status.idle      = (pend == '0);
  assign status.bit_index = bit_index;

endmodule

/* src/irpe_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// irpe_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module irpe_cmd_fifo
  import irpe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* src/irpe_back.sv */
// ----------------------------------------------------------------------------
// irpe_back
// Expands commands into words in an output register, one per cycle unless held.
// ----------------------------------------------------------------------------
module irpe_back
  import irpe_pkg::*;
#(
  parameter int SLOTS_PER_LIST = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int SW = (SLOTS_PER_LIST > 1) ? $clog2(SLOTS_PER_LIST) : 1;

  logic              busy;
  cmd_t              cur;
  logic [SW-1:0]     slot;
  logic [GAP_W-1:0]  gap_rem;

  logic              advance;
  logic [LIST_W-1:0] list;
  logic [SLOT_W-1:0] word_now;
  logic [SLOT_W-1:0] word_nxt;
  logic [TICK_W-1:0] ticks;
  logic              level;
  logic              done;

  function automatic logic [SLOT_W-1:0] slot_word(input logic [LIST_W-1:0] l,
                                                  input logic [SW:0] idx);
    logic [SLOT_W-1:0] w;
    w = '0;
    for (int s = 0; s < SLOTS_PER_LIST; s++) begin
      if (idx == (SW+1)'(s)) begin
        w = l[SLOT_W*s +: SLOT_W];
      end
    end
    return w;
  endfunction

  assign advance = !out_valid || out_ready;

  always_comb begin
    case (cur.kind)
      CMD_HEADER:  list = cfg.header_pulses;
      CMD_TRAILER: list = cfg.trailer_pulses;
      CMD_ONE:     list = cfg.one_pulses;
      default:     list = cfg.zero_pulses;
    endcase
  end

  assign word_now = slot_word(list, {1'b0, slot});
  assign word_nxt = slot_word(list, {1'b0, slot} + 1'b1);

  always_comb begin
    if (cur.kind == CMD_GAP) begin
      level = 1'b0;
      ticks = (gap_rem > GAP_W'(TICK_MAX)) ? TICK_MAX : gap_rem[TICK_W-1:0];
      done  = (gap_rem <= GAP_W'(TICK_MAX));
    end else begin
      level = word_now[SLOT_W-1];
      if (!cur.dbl) begin
        ticks = word_now[TICK_W-1:0];
      end else if (word_now[TICK_W-1]) begin
        ticks = TICK_MAX;  // doubling saturates
      end else begin
        ticks = {word_now[TICK_W-2:0], 1'b0};
      end
      done = (slot == SW'(SLOTS_PER_LIST-1)) || (word_nxt[TICK_W-1:0] == '0);
    end
  end

  assign pop = !empty && (!busy || (advance && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && advance) begin
        out_valid <= 1'b1;
        if (done) begin
          busy <= 1'b0;
        end
      end else if (advance) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && advance) begin
      out_data.pulse_level <= level;
      out_data.pulse_ticks <= ticks;
      out_data.run_end     <= done && cur.is_last;
      slot                 <= slot + 1'b1;
      gap_rem              <= gap_rem - GAP_W'(TICK_MAX);
    end
    if (pop) begin
      cur     <= head;
      slot    <= '0;
      gap_rem <= cfg.gap_ticks;
    end
  end

endmodule

/* tb/irpe_pulse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpe_pulse_checker
// Watches the register port and both streams of the pulse-train encoder.
// Keeps its own copy of the registers and the frame bit position, expands
// every accepted item into the pulse words it should cause, and compares
// each accepted pulse word with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module irpe_pulse_checker
  import irpe_pkg::*;
#(
  parameter int SLOTS_PER_LIST = 4,
  parameter int MAX_BITS       = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LIST_W-1:0]    cfg_data,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  in_item_t             item,
  input  logic                 word_valid,
  input  logic                 word_ready,
  input  out_word_t            word,
  output int unsigned          fails,
  output int unsigned          pending
);

  cfg_t              regs;
  logic [BIDX_W-1:0] frame_bit;
  out_word_t         pulse_q[$];

  function automatic void add_word(logic level, logic [TICK_W-1:0] ticks);
    out_word_t w;
    w.pulse_level = level;
    w.pulse_ticks = ticks;
    w.run_end     = 1'b0;
    pulse_q.push_back(w);
  endfunction

  // a slot with zero ticks ends the list, whatever its level bit
  function automatic void add_list(logic [LIST_W-1:0] list, logic dbl);
    logic [TICK_W-1:0] t;
    logic [TICK_W:0]   scaled;
    for (int s = 0; s < SLOTS_PER_LIST; s++) begin
      t = list[SLOT_W*s +: TICK_W];
      if (t == '0) break;
      scaled = dbl ? {t, 1'b0} : {1'b0, t};
      if (scaled > TICK_MAX) scaled = TICK_MAX;
      add_word(list[SLOT_W*s + TICK_W], scaled[TICK_W-1:0]);
    end
  endfunction

  function automatic void expand_item(in_item_t it);
    int                base;
    int                limit;
    logic [GAP_W-1:0]  gap;
    base  = pulse_q.size();
    limit = (regs.bit_count > MAX_BITS) ? MAX_BITS : int'(regs.bit_count);
    if (it.first) begin
      frame_bit = '0;
      add_list(regs.header_pulses, 1'b0);
    end
    for (int b = NIB_W - 1; b >= 0; b--) begin
      if (frame_bit >= limit) break;
      add_list(it.nibble[b] ? regs.one_pulses : regs.zero_pulses,
               regs.rc6_mode && (frame_bit == RC6_DOUBLE_POS));
      frame_bit = frame_bit + 1'b1;
    end
    if (it.last) begin
      add_list(regs.trailer_pulses, 1'b0);
      gap = regs.gap_ticks;
      while (gap > TICK_MAX) begin
        add_word(1'b0, TICK_MAX);
        gap = gap - TICK_MAX;
      end
      if (gap != '0) add_word(1'b0, gap[TICK_W-1:0]);
      frame_bit = '0;
    end
    if (pulse_q.size() > base) pulse_q[pulse_q.size()-1].run_end = 1'b1;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      regs.header_pulses  = '0;
      regs.trailer_pulses = '0;
      regs.zero_pulses    = '0;
      regs.one_pulses     = '0;
      regs.bit_count      = BIT_COUNT_RST;
      regs.rc6_mode       = 1'b0;
      regs.gap_ticks      = '0;
      frame_bit           = '0;
      pulse_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_HEADER:  regs.header_pulses  = cfg_data;
          REG_TRAILER: regs.trailer_pulses = cfg_data;
          REG_ZERO:    regs.zero_pulses    = cfg_data;
          REG_ONE:     regs.one_pulses     = cfg_data;
          REG_BITCNT:  regs.bit_count      = cfg_data[BIDX_W-1:0];
          REG_RC6:     regs.rc6_mode       = cfg_data[0];
          REG_GAP:     regs.gap_ticks      = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) expand_item(item);
      if (word_valid && word_ready) begin
        if (pulse_q.size() == 0) begin
          $error("unexpected pulse word: level %0d ticks %0d run_end %0d",
                 word.pulse_level, word.pulse_ticks, word.run_end);
          fails++;
        end else begin
          exp_w = pulse_q.pop_front();
          if (word.pulse_level !== exp_w.pulse_level) begin
            $error("pulse_level mismatch: expected %0d, got %0d",
                   exp_w.pulse_level, word.pulse_level);
            fails++;
          end
          if (word.pulse_ticks !== exp_w.pulse_ticks) begin
            $error("pulse_ticks mismatch: expected %0d, got %0d",
                   exp_w.pulse_ticks, word.pulse_ticks);
            fails++;
          end
          if (word.run_end !== exp_w.run_end) begin
            $error("run_end mismatch: expected %0d, got %0d",
                   exp_w.run_end, word.run_end);
            fails++;
          end
        end
      end
    end
    pending = pulse_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the infrared pulse-train encoder. Loads several
// register sets (defaults, remote-style timings, full lists with doubling
// and the longest gap, zero bit count, then random sets), sends directed
// and random nibble frames with random gaps and output stalls, and reports
// the failure count gathered by the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import irpe_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 33;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_HEADER;
  logic [LIST_W-1:0]    cfg_data = '0;

  bit          hold_req = 1'b0;
  bit          steady_send = 1'b0;
  int unsigned fails;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  irpe_stream_if #(.T(in_item_t))  items_if ();
  irpe_stream_if #(.T(out_word_t)) pulses_if ();

  ir_pulse_train_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .items    (items_if),
    .pulses   (pulses_if)
  );

  irpe_pulse_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .item_valid (items_if.valid),
    .item_ready (items_if.ready),
    .item       (items_if.data),
    .word_valid (pulses_if.valid),
    .word_ready (pulses_if.ready),
    .word       (pulses_if.data),
    .fails      (fails),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // runs until nothing moves on either stream for too long
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (pulses_if.valid && pulses_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ir_pulse_train_encoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls, stretches of steady ready, one long hold-off
  initial begin : sink_side
    int run;
    int hold;
    pulses_if.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pulses_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      run = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      pulses_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        pulses_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [NIB_W-1:0] nib, input logic f, input logic l);
    int       gap;
    in_item_t it;
    gap = steady_send ? 0 : pick_gap();
    it.nibble = nib;
    it.first  = f;
    it.last   = l;
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
  endtask

  // let every outstanding word arrive, then let the pipeline settle
  task automatic drain();
    items_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIST_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    put_reg(REG_HEADER,  c.header_pulses);
    put_reg(REG_TRAILER, c.trailer_pulses);
    put_reg(REG_ZERO,    c.zero_pulses);
    put_reg(REG_ONE,     c.one_pulses);
    put_reg(REG_BITCNT,  LIST_W'(c.bit_count));
    put_reg(REG_RC6,     LIST_W'(c.rc6_mode));
    put_reg(REG_GAP,     LIST_W'(c.gap_ticks));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // live slots, then an ending slot with a random level if room is left, then junk
  function automatic logic [LIST_W-1:0] rand_list();
    logic [LIST_W-1:0] l;
    logic [TICK_W-1:0] t;
    int                n;
    int                r;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, SLOT_W / 4);
    for (int s = 0; s < LIST_W / SLOT_W; s++) begin
      if (s < n) begin
        r = $urandom_range(0, 99);
        if (r < 50)      t = TICK_W'($urandom_range(1, 2000));
        else if (r < 80) t = TICK_W'($urandom_range(2001, 32767));
        else if (r < 90) t = TICK_MAX;
        else             t = TICK_W'($urandom_range(16383, 16384));
        l[SLOT_W*s +: SLOT_W] = {1'($urandom_range(0, 1)), t};
      end else if (s == n) begin
        l[SLOT_W*s +: SLOT_W] = {1'($urandom_range(0, 1)), {TICK_W{1'b0}}};
      end else begin
        l[SLOT_W*s +: SLOT_W] = SLOT_W'($urandom());
      end
    end
    return l;
  endfunction

  function automatic cfg_t rand_regs();
    cfg_t c;
    c.header_pulses  = rand_list();
    c.trailer_pulses = rand_list();
    c.zero_pulses    = rand_list();
    c.one_pulses     = rand_list();
    case ($urandom_range(0, 5))
      0:       c.bit_count = '0;
      1:       c.bit_count = BIDX_W'(64);
      2:       c.bit_count = BIDX_W'($urandom_range(65, 127));
      default: c.bit_count = BIDX_W'($urandom_range(1, 40));
    endcase
    c.rc6_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0:       c.gap_ticks = '0;
      1:       c.gap_ticks = GAP_W'(32767);
      2:       c.gap_ticks = GAP_W'(32768);
      3:       c.gap_ticks = '1;
      4:       c.gap_ticks = GAP_W'($urandom_range(1, 100));
      default: c.gap_ticks = GAP_W'($urandom());
    endcase
    return c;
  endfunction

  // mostly whole frames with random data, some items with random flags
  task automatic random_items(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(NIB_W'($urandom()), 1'($urandom()), 1'($urandom()));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) send_item(NIB_W'($urandom()), k == 0, k == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    items_if.valid = 1'b0;
    items_if.data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: empty lists and no gap, so nothing comes out
    send_item(4'hA, 1'b1, 1'b0);
    send_item(4'h5, 1'b0, 1'b1);
    drain();

    // remote-style timings, six data bits, gap of exactly one chunk;
    // trailer ends on a slot with level set and junk behind it
    c.header_pulses  = {16'h0000, 16'h0000, 16'h1194, 16'hA328};
    c.trailer_pulses = {16'h1234, 16'h5678, 16'h8000, 16'h8230};
    c.zero_pulses    = {16'h0000, 16'h0000, 16'h0230, 16'h8230};
    c.one_pulses     = {16'h0000, 16'h0000, 16'h069A, 16'h8230};
    c.bit_count      = BIDX_W'(6);
    c.rc6_mode       = 1'b0;
    c.gap_ticks      = GAP_W'(32767);
    load_regs(c);
    // output held off while items keep coming, so the block backs up
    hold_req = 1'b1;
    wait (!hold_req);
    send_item(4'h0, 1'b1, 1'b0);
    send_item(4'hF, 1'b0, 1'b0);
    send_item(4'h9, 1'b0, 1'b1);
    send_item(4'h3, 1'b1, 1'b1);
    send_item(4'hC, 1'b0, 1'b0);
    send_item(4'h6, 1'b0, 1'b1);
    drain();

    // full lists, saturating doubled bit, bit count past the maximum,
    // longest gap: a single first-and-last item gives the most words
    c.header_pulses  = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    c.trailer_pulses = {16'h8001, 16'h0001, 16'hFFFF, 16'h7FFF};
    c.zero_pulses    = {16'hC000, 16'h4000, 16'h7FFF, 16'h8001};
    c.one_pulses     = {16'h3FFF, 16'h8002, 16'h0001, 16'hFFFF};
    c.bit_count      = '1;
    c.rc6_mode       = 1'b1;
    c.gap_ticks      = '1;
    load_regs(c);
    send_item(4'hF, 1'b1, 1'b1);
    send_item(4'h0, 1'b1, 1'b0);
    send_item(4'h5, 1'b0, 1'b0);
    send_item(4'hE, 1'b0, 1'b1);
    drain();

    // zero bit count: data bits send nothing, shortest gap
    c.header_pulses  = {48'h0, 16'h8064};
    c.trailer_pulses = {48'h0, 16'h0032};
    c.zero_pulses    = {48'h0, 16'h8008};
    c.one_pulses     = {32'h0, 16'h0010, 16'h8010};
    c.bit_count      = '0;
    c.rc6_mode       = 1'b0;
    c.gap_ticks      = GAP_W'(1);
    load_regs(c);
    send_item(4'hF, 1'b1, 1'b0);
    send_item(4'h3, 1'b0, 1'b1);
    send_item(4'h8, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c = rand_regs();
      load_regs(c);
      steady_send = ($urandom_range(0, 3) == 0);
      random_items(PHASE_ITEMS);
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("ir_pulse_train_encoder test passed");
    end else begin
      $display("ir_pulse_train_encoder test failed");
    end
    $finish;
  end

endmodule

/* ir_pulse_train_encoder.f */
src/irpe_pkg.sv
src/irpe_stream_if.sv
src/irpe_front.sv
src/irpe_cmd_fifo.sv
src/irpe_back.sv
src/ir_pulse_train_encoder.sv
tb/irpe_pulse_checker.sv
tb/tb_top.sv
